// ===== rtl/sha_bsh_pkg.sv =====
`timescale 1ns / 1ps

package sha_bsh_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned ROUNDS      = 64;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam logic [5:0]  LAST_FILL   = 6'd63;
    localparam logic [5:0]  LAST_ROUND  = 6'd63;
    localparam logic [2:0]  LAST_WORD   = 3'd7;
    localparam logic        OP_ABSORB   = 1'b0;
    localparam logic        OP_FINISH   = 1'b1;

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INITIAL_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_FOLD,
        S_EMIT
    } state_t;

    // Commands from the sequencer to the round datapath.
    typedef struct packed {
        logic       load_byte;
        logic [7:0] byte_val;
        logic       init_work;
        logic       do_round;
        logic [5:0] rnd;
        logic       fold;
        logic       chain_init;
    } ctrl_t;

endpackage

// ===== rtl/sha_bsh_round.sv =====
`timescale 1ns / 1ps

module sha_bsh_round
    import sha_bsh_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  ctrl_t            ctrl,
    output logic [7:0][31:0] chain
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // The schedule window doubles as the block buffer: bytes are shifted in
    // at the bottom, so the first byte of the block ends up at the top of word 0.
    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];
    logic [31:0] work_reg [8];
    logic [31:0] work_next [8];
    logic [7:0][31:0] chain_reg;
    logic [7:0][31:0] chain_next;

    logic [31:0] w_cur, s0, s1, t1, t2;
    logic [31:0] a, b, c, d, e, f, g, h;

    assign a = work_reg[0];
    assign b = work_reg[1];
    assign c = work_reg[2];
    assign d = work_reg[3];
    assign e = work_reg[4];
    assign f = work_reg[5];
    assign g = work_reg[6];
    assign h = work_reg[7];

    always_comb begin
        s0 = rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3);
        s1 = rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10);
        if (ctrl.rnd[5:4] == 2'b00) begin
            w_cur = win_reg[0];
        end else begin
            w_cur = s1 + win_reg[9] + s0 + win_reg[0];
        end
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + ROUND_K[ctrl.rnd] + w_cur;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    end

    always_comb begin
        win_next = win_reg;
        if (ctrl.load_byte) begin
            for (int i = 0; i < 15; i++) begin
                win_next[i] = {win_reg[i][23:0], win_reg[i+1][31:24]};
            end
            win_next[15] = {win_reg[15][23:0], ctrl.byte_val};
        end else if (ctrl.do_round) begin
            for (int i = 0; i < 15; i++) begin
                win_next[i] = win_reg[i+1];
            end
            win_next[15] = w_cur;
        end
    end

    always_comb begin
        work_next = work_reg;
        if (ctrl.init_work) begin
            for (int j = 0; j < 8; j++) begin
                work_next[j] = chain_reg[j];
            end
        end else if (ctrl.do_round) begin
            work_next[7] = g;
            work_next[6] = f;
            work_next[5] = e;
            work_next[4] = d + t1;
            work_next[3] = c;
            work_next[2] = b;
            work_next[1] = a;
            work_next[0] = t1 + t2;
        end
    end

    always_comb begin
        chain_next = chain_reg;
        if (ctrl.chain_init) begin
            for (int j = 0; j < 8; j++) begin
                chain_next[j] = INITIAL_HASH[j];
            end
        end else if (ctrl.fold) begin
            for (int j = 0; j < 8; j++) begin
                chain_next[j] = chain_reg[j] + work_reg[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        win_reg  <= win_next;
        work_reg <= work_next;
        if (!aresetn) begin
            for (int j = 0; j < 8; j++) begin
                chain_reg[j] <= INITIAL_HASH[j];
            end
        end else begin
            chain_reg <= chain_next;
        end
    end

    assign chain = chain_reg;

endmodule

// ===== rtl/sha256_byte_stream_hasher_core.sv =====
`timescale 1ns / 1ps

// Channel  Ports                                   Direction  Beat
// s_       s_valid s_ready s_op s_data_byte        in         one byte or a finish command
// m_       m_valid m_ready m_digest_word           out        one digest word, eight per finish
//          m_word_index m_last_word
//
// An absorb beat shifts in one byte; the 64th byte of a block is followed by the 64 rounds
// of the compression and a fold of the working variables into the chain value.
// A finish beat writes the padding one byte a cycle, runs one or two compressions
// and then loads the eight digest words into the output register, one per free slot.
// aresetn is synchronous and active low; it restores the initial hash values.
// s_ready is low for the whole of a compression, the padding and the digest output.

module sha256_byte_stream_hasher_core
    import sha_bsh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    state_t state_reg, state_next;
    ctrl_t  ctrl;

    logic [5:0]       fill_reg;
    logic [60:0]      len_reg;
    logic [7:0][7:0]  bitlen_reg;
    logic [5:0]       rnd_reg;
    logic [2:0]       idx_reg;
    logic             finishing_reg;
    logic             zero_blk_reg;
    logic             len_done_reg;
    logic             m_valid_reg;
    logic [31:0]      m_digest_reg;
    logic [2:0]       m_index_reg;
    logic             m_last_reg;

    logic             s_fire;
    logic             out_load;
    logic [7:0]       pad_byte;
    logic [7:0][31:0] chain;

    assign s_fire = s_valid && s_ready;

    // Length bytes go only into the block that has room for them; a block
    // opened by a late pad marker is filled with zeros to its end.
    always_comb begin
        if (fill_reg[5:3] == 3'b111 && !zero_blk_reg) begin
            pad_byte = bitlen_reg[~fill_reg[2:0]];
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire && fill_reg == LAST_FILL) begin
                    state_next = S_ROUND;
                end else if (s_fire && s_op == OP_FINISH) begin
                    state_next = S_PAD;
                end
            end
            S_PAD: begin
                if (fill_reg == LAST_FILL) begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND: begin
                if (rnd_reg == LAST_ROUND) begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD: begin
                priority if (len_done_reg) begin
                    state_next = S_EMIT;
                end else if (finishing_reg) begin
                    state_next = S_PAD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_load && idx_reg == LAST_WORD) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        out_load = 1'b0;
        ctrl     = '0;
        ctrl.rnd = rnd_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready        = 1'b1;
                ctrl.load_byte = s_fire;
                ctrl.byte_val  = (s_op == OP_FINISH) ? PAD_BYTE : s_data_byte;
                ctrl.init_work = s_fire && fill_reg == LAST_FILL;
            end
            S_PAD: begin
                ctrl.load_byte = 1'b1;
                ctrl.byte_val  = pad_byte;
                ctrl.init_work = fill_reg == LAST_FILL;
            end
            S_ROUND: begin
                ctrl.do_round = 1'b1;
            end
            S_FOLD: begin
                ctrl.fold = 1'b1;
            end
            S_EMIT: begin
                out_load        = !m_valid_reg || m_ready;
                ctrl.chain_init = out_load && idx_reg == LAST_WORD;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            len_reg       <= '0;
            rnd_reg       <= '0;
            idx_reg       <= '0;
            finishing_reg <= 1'b0;
            zero_blk_reg  <= 1'b0;
            len_done_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ctrl.load_byte) begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (s_fire && s_op == OP_ABSORB) begin
                len_reg <= len_reg + 61'd1;
            end
            // A marker in the last byte closes its block at once, so the next
            // block already has room for the length.
            if (s_fire && s_op == OP_FINISH) begin
                finishing_reg <= 1'b1;
                zero_blk_reg  <= fill_reg[5:3] == 3'b111 && fill_reg != LAST_FILL;
            end
            if (state_reg == S_PAD && fill_reg == LAST_FILL) begin
                if (zero_blk_reg) begin
                    zero_blk_reg <= 1'b0;
                end else begin
                    len_done_reg <= 1'b1;
                end
            end
            if (ctrl.do_round) begin
                rnd_reg <= rnd_reg + 6'd1;
            end
            if (out_load) begin
                idx_reg <= idx_reg + 3'd1;
                if (idx_reg == LAST_WORD) begin
                    finishing_reg <= 1'b0;
                    len_done_reg  <= 1'b0;
                    len_reg       <= '0;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_op == OP_FINISH) begin
            bitlen_reg <= {len_reg, 3'b000};
        end
        if (out_load) begin
            m_digest_reg <= chain[idx_reg];
            m_index_reg  <= idx_reg;
            m_last_reg   <= idx_reg == LAST_WORD;
        end
    end

    sha_bsh_round u_round (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .chain   (chain)
    );

    assign m_valid       = m_valid_reg;
    assign m_digest_word = m_digest_reg;
    assign m_word_index  = m_index_reg;
    assign m_last_word   = m_last_reg;

endmodule
